[rtl/core/xor_weighted_union_find_core_macros.svh]
// assertion macros for the xor weighted union find core
`ifndef XOR_WEIGHTED_UNION_FIND_CORE_MACROS_SVH
`define XOR_WEIGHTED_UNION_FIND_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define XWUF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("xwuf assertion failed");
`define XWUF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("xwuf assertion failed");
`else
`define XWUF_ASSERT(lbl, prop)
`define XWUF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/core/xwuf_pkg.sv]
// shared constants and codes for the xor weighted union find core
`default_nettype none
package xwuf_pkg;
    localparam int MAX_NODES = 16384;
    localparam int MAX_GROUP = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int SLOT_W    = $clog2(MAX_GROUP);
    localparam int GCNT_W    = $clog2(MAX_GROUP + 1);
    localparam int VAL_W     = 31;
    localparam int CNT_W     = 20;
    localparam int MEM_W     = NODE_W + VAL_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] CMD_PAIR  = 2'd0;
    localparam logic [1:0] CMD_VALUE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [2:0] ST_ACCEPT   = 3'd0;
    localparam logic [2:0] ST_CONFLICT = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_ANSWER   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;

    localparam logic [2:0] REG_NUM_VARS = 3'd0;
endpackage
`default_nettype wire

[rtl/core/xor_weighted_union_find_core.sv]
// xor weighted union find core: node memory, root walk with path compression
//
// channel   direction  handshake          payload
// input     in         i_valid / o_ready  command, first/second index, value, last
// result    out        o_valid / i_ready  status, fact_number, answer_value
// config    in         apb psel/penable   num_vars at byte address 0
//
// one beat at a time; a root walk climbs with a read and a check per link, compresses
// with a read and a write per link and then finishes, all on the single port of the node memory.
// a fact takes two walks and a link write when the roots differ; a query element one walk.
// reset and the clear command start a clearing pass over all 16384 nodes, ready low.
// a finished result waits in the output register; the next beat is taken meanwhile.
`default_nettype none
`include "xor_weighted_union_find_core_macros.svh"
module xor_weighted_union_find_core
    import xwuf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_command,
    input  wire logic [NODE_W-1:0] i_first_index,
    input  wire logic [NODE_W-1:0] i_second_index,
    input  wire logic [VAL_W-1:0]  i_fact_value,
    input  wire logic              i_group_last,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [2:0]             o_status,
    output logic [CNT_W-1:0]       o_fact_number,
    output logic [VAL_W-1:0]       o_answer_value,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_WRD  = 4'd2;
    localparam logic [3:0] S_WCHK = 4'd3;
    localparam logic [3:0] S_CRD  = 4'd4;
    localparam logic [3:0] S_CWR  = 4'd5;
    localparam logic [3:0] S_DONE = 4'd6;
    localparam logic [3:0] S_UNI  = 4'd7;
    localparam logic [3:0] S_QFIN = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_Q = 2'd2;

    logic [3:0]        r_state;
    logic [1:0]        r_phase;
    logic [NODE_W-1:0] r_num_vars;
    logic [NODE_W-1:0] r_clr_idx;
    logic [NODE_W-1:0] r_cur, r_start, r_root, r_ra, r_b;
    logic [VAL_W-1:0]  r_tot, r_acc, r_ta, r_w, r_qacc, r_res_ans;
    logic [2:0]        r_res_status;
    logic              r_last, r_conflict, r_bad;
    logic [CNT_W-1:0]  r_cnt;
    logic [GCNT_W-1:0] r_glen, r_nslot, r_odd;
    logic [NODE_W-1:0] r_slot [MAX_GROUP];
    logic [MAX_GROUP-1:0] r_par;
    logic              r_ov;
    logic [2:0]        r_o_status;
    logic [CNT_W-1:0]  r_o_cnt;
    logic [VAL_W-1:0]  r_o_ans;

    // node memory: parent link over offset to parent
    logic [MEM_W-1:0]  mem [MAX_NODES];
    logic [MEM_W-1:0]  r_rd;
    logic              mem_we, mem_re;
    logic [NODE_W-1:0] mem_wa;
    logic [MEM_W-1:0]  mem_wd;
    logic [NODE_W-1:0] rd_par;
    logic [VAL_W-1:0]  rd_off;

    assign rd_par = r_rd[MEM_W-1:VAL_W];
    assign rd_off = r_rd[VAL_W-1:0];

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cur;
        mem_wd = {r_root, r_acc};
        mem_re = (r_state == S_WRD) || ((r_state == S_CRD) && (r_cur != r_root));
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_idx;
                mem_wd = {r_clr_idx, {VAL_W{1'b0}}};
            end
            S_CWR: begin
                mem_we = 1'b1;
            end
            S_UNI: begin
                mem_we = 1'b1;
                mem_wa = (r_ra == r_num_vars) ? r_root : r_ra;
                mem_wd = {((r_ra == r_num_vars) ? r_ra : r_root), r_ta ^ r_tot ^ r_w};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[r_cur];
        end
    end

    // configuration port
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == REG_NUM_VARS);
    assign prdata = (paddr == REG_NUM_VARS) ? {{(32-NODE_W){1'b0}}, r_num_vars} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars <= NODE_W'(MAX_NODES - 1);
        end else if (cfg_we) begin
            r_num_vars <= pwdata[NODE_W-1:0];
        end
    end

    // group slot lookup
    logic [MAX_GROUP-1:0] hit;
    logic                 hit_any;
    logic [SLOT_W-1:0]    hit_idx;
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < MAX_GROUP; i++) begin
            hit[i] = (GCNT_W'(i) < r_nslot) && (r_slot[i] == r_root);
            if (hit[i]) begin
                hit_idx = SLOT_W'(i);
            end
        end
        hit_any = |hit;
    end

    logic             acc_in;
    logic [NODE_W-1:0] b_sel;
    assign o_ready = (r_state == S_IDLE);
    assign acc_in  = i_valid && o_ready;
    assign b_sel   = (i_command == CMD_VALUE) ? r_num_vars : i_second_index;

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_idx  <= '0;
            r_conflict <= 1'b0;
            r_cnt      <= '0;
            r_glen     <= '0;
            r_nslot    <= '0;
            r_odd      <= '0;
            r_bad      <= 1'b0;
            r_qacc     <= '0;
            r_par      <= '0;
            r_ov       <= 1'b0;
            r_phase    <= PH_A;
        end else begin
            if (r_ov && i_ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == {NODE_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc_in) begin
                        r_w    <= i_fact_value;
                        r_last <= i_group_last;
                        r_res_ans <= '0;
                        r_cur   <= i_first_index;
                        r_start <= i_first_index;
                        r_tot   <= '0;
                        if (i_command == CMD_CLEAR) begin
                            r_state    <= S_CLR;
                            r_clr_idx  <= '0;
                            r_conflict <= 1'b0;
                            r_cnt      <= '0;
                            r_glen     <= '0;
                            r_nslot    <= '0;
                            r_odd      <= '0;
                            r_bad      <= 1'b0;
                            r_qacc     <= '0;
                            r_par      <= '0;
                        end else if (r_conflict) begin
                            r_res_status <= ST_IGNORED;
                            r_state      <= S_OUT;
                        end else if (i_command == CMD_QUERY) begin
                            if (i_first_index > r_num_vars) begin
                                r_bad   <= 1'b1;
                                r_state <= i_group_last ? S_QFIN : S_IDLE;
                            end else begin
                                r_phase <= PH_Q;
                                r_state <= S_WRD;
                            end
                        end else if ((i_first_index > r_num_vars) || (b_sel > r_num_vars)) begin
                            r_res_status <= ST_IGNORED;
                            r_state      <= S_OUT;
                        end else begin
                            if (r_cnt != CNT_MAX) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                            r_b     <= b_sel;
                            r_phase <= PH_A;
                            r_state <= S_WRD;
                        end
                    end
                end
                S_WRD: begin
                    r_state <= S_WCHK;
                end
                S_WCHK: begin
                    if (rd_par == r_cur) begin
                        r_root  <= r_cur;
                        r_acc   <= r_tot;
                        r_cur   <= r_start;
                        r_state <= S_CRD;
                    end else begin
                        r_tot   <= r_tot ^ rd_off;
                        r_cur   <= rd_par;
                        r_state <= S_WRD;
                    end
                end
                S_CRD: begin
                    r_state <= (r_cur == r_root) ? S_DONE : S_CWR;
                end
                S_CWR: begin
                    r_acc   <= r_acc ^ rd_off;
                    r_cur   <= rd_par;
                    r_state <= S_CRD;
                end
                S_DONE: begin
                    unique case (r_phase)
                        PH_A: begin
                            r_ra    <= r_root;
                            r_ta    <= r_tot;
                            r_cur   <= r_b;
                            r_start <= r_b;
                            r_tot   <= '0;
                            r_phase <= PH_B;
                            r_state <= S_WRD;
                        end
                        PH_B: begin
                            if (r_ra != r_root) begin
                                r_state <= S_UNI;
                            end else if ((r_ta ^ r_tot) != r_w) begin
                                r_conflict   <= 1'b1;
                                r_res_status <= ST_CONFLICT;
                                r_state      <= S_OUT;
                            end else begin
                                r_res_status <= ST_ACCEPT;
                                r_state      <= S_OUT;
                            end
                        end
                        default: begin
                            r_qacc <= r_qacc ^ r_tot;
                            if (r_root != r_num_vars) begin
                                if (r_glen < GCNT_W'(MAX_GROUP)) begin
                                    r_glen <= r_glen + 1'b1;
                                    if (hit_any) begin
                                        r_par[hit_idx] <= ~r_par[hit_idx];
                                        r_odd <= r_par[hit_idx] ? r_odd - 1'b1 : r_odd + 1'b1;
                                    end else begin
                                        r_slot[r_nslot[SLOT_W-1:0]] <= r_root;
                                        r_par[r_nslot[SLOT_W-1:0]]  <= 1'b1;
                                        r_nslot <= r_nslot + 1'b1;
                                        r_odd   <= r_odd + 1'b1;
                                    end
                                end else begin
                                    r_bad <= 1'b1;
                                end
                            end
                            r_state <= r_last ? S_QFIN : S_IDLE;
                        end
                    endcase
                end
                S_UNI: begin
                    r_res_status <= ST_ACCEPT;
                    r_state      <= S_OUT;
                end
                S_QFIN: begin
                    if (!r_bad && (r_odd == '0)) begin
                        r_res_status <= ST_ANSWER;
                        r_res_ans    <= r_qacc;
                    end else begin
                        r_res_status <= ST_UNKNOWN;
                        r_res_ans    <= '0;
                    end
                    r_glen  <= '0;
                    r_nslot <= '0;
                    r_odd   <= '0;
                    r_bad   <= 1'b0;
                    r_qacc  <= '0;
                    r_par   <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_ov || i_ready)) begin
            r_o_status <= r_res_status;
            r_o_cnt    <= r_cnt;
            r_o_ans    <= r_res_ans;
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_o_status;
    assign o_fact_number  = r_o_cnt;
    assign o_answer_value = r_o_ans;

    // checks
    `XWUF_ASSERT(a_slots_le_len, r_nslot <= r_glen)
    `XWUF_ASSERT(a_odd_le_slots, r_odd <= r_nslot)
    `XWUF_ASSERT(a_conflict_ignores, acc_in && r_conflict && (i_command != CMD_CLEAR) |=> r_state == S_OUT)
    `XWUF_ASSERT(a_out_holds, r_ov && !i_ready |=> r_ov && $stable(r_o_status))
    `XWUF_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (r_state == S_CLR) && !r_ov)
endmodule
`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for the xor weighted union find core
module testbench;
    import xwuf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]        command;
        logic [NODE_W-1:0] first_index;
        logic [NODE_W-1:0] second_index;
        logic [VAL_W-1:0]  fact_value;
        logic              group_last;
    } item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] fact_number;
        logic [VAL_W-1:0] answer_value;
    } outcome_t;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic [1:0] i_command;
    logic [NODE_W-1:0] i_first_index, i_second_index;
    logic [VAL_W-1:0] i_fact_value;
    logic i_group_last;
    logic [2:0] o_status;
    logic [CNT_W-1:0] o_fact_number;
    logic [VAL_W-1:0] o_answer_value;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    xor_weighted_union_find_core u_top (.*);

    // golden store
    logic [NODE_W-1:0] up_link [MAX_NODES];
    logic [VAL_W-1:0]  up_off [MAX_NODES];
    logic              parity [MAX_NODES];
    logic [NODE_W-1:0] group_roots [MAX_GROUP];
    logic [NODE_W-1:0] var_count;
    logic              in_conflict;
    logic [CNT_W-1:0]  fact_count;
    logic [VAL_W-1:0]  group_xor;
    int                odd_roots, group_len;
    logic              group_unknown;

    item_t    pending_items[$];
    outcome_t expected_outcomes[$];
    int mismatches, results_seen, answers_seen, conflicts_seen, accepted;
    logic stim_done;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #500ms;
        $display("testbench failed");
        $finish;
    end

    // append to the stimulus and expectation queues
    function automatic void add_item(item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void add_outcome(outcome_t o);
        expected_outcomes = {expected_outcomes, o};
    endfunction

    function automatic logic [NODE_W-1:0] virtual_node();
        return var_count;
    endfunction

    function automatic void reset_group();
        for (int i = 0; i < group_len; i++) parity[group_roots[i]] = 0;
        group_len = 0;
        odd_roots = 0;
        group_xor = '0;
        group_unknown = 0;
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < MAX_NODES; i++) begin
            up_link[i] = i[NODE_W-1:0];
            up_off[i] = '0;
            parity[i] = 0;
        end
        in_conflict = 0;
        fact_count = '0;
        group_len = 0;
        odd_roots = 0;
        group_xor = '0;
        group_unknown = 0;
    endfunction

    // walk to the root and compress the path
    function automatic logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] r, y, nxt;
        logic [VAL_W-1:0] acc, off;
        r = node;
        acc = '0;
        while (up_link[r] != r) begin
            acc ^= up_off[r];
            r = up_link[r];
        end
        y = node;
        while (y != r) begin
            nxt = up_link[y];
            off = up_off[y];
            up_link[y] = r;
            up_off[y] = acc;
            acc ^= off;
            y = nxt;
        end
        return r;
    endfunction

    function automatic void predict(item_t it);
        logic [NODE_W-1:0] a, b, ra, rb, t, vn;
        logic [VAL_W-1:0] oa, ob;
        outcome_t o;
        vn = virtual_node();
        a = it.first_index;
        b = it.second_index;
        o = '0;
        if (it.command == CMD_CLEAR) begin
            wipe_store();
            return;
        end
        if (in_conflict) begin
            o.status = ST_IGNORED;
            o.fact_number = fact_count;
            add_outcome(o);
            return;
        end
        if (it.command == CMD_PAIR || it.command == CMD_VALUE) begin
            if (it.command == CMD_VALUE) b = vn;
            if (a > vn || b > vn) begin
                o.status = ST_IGNORED;
            end else begin
                if (fact_count != CNT_MAX) fact_count++;
                ra = find_root(a);
                rb = find_root(b);
                o.status = ST_ACCEPT;
                if (ra == rb) begin
                    if ((up_off[a] ^ up_off[b]) != it.fact_value
                        && !(a == ra && b == rb && it.fact_value == 0)) begin
                        in_conflict = 1;
                        o.status = ST_CONFLICT;
                    end
                end else begin
                    oa = (a == ra) ? '0 : up_off[a];
                    ob = (b == rb) ? '0 : up_off[b];
                    if (ra == vn) begin
                        t = ra; ra = rb; rb = t;
                    end
                    up_link[ra] = rb;
                    up_off[ra] = oa ^ ob ^ it.fact_value;
                end
            end
            o.fact_number = fact_count;
            add_outcome(o);
            return;
        end
        // query element
        if (a > vn) begin
            group_unknown = 1;
        end else begin
            ra = find_root(a);
            if (a != ra) group_xor ^= up_off[a];
            if (ra != vn) begin
                if (group_len < MAX_GROUP) begin
                    group_roots[group_len] = ra;
                    group_len++;
                    parity[ra] = ~parity[ra];
                    odd_roots += parity[ra] ? 1 : -1;
                end else begin
                    group_unknown = 1;
                end
            end
        end
        if (!it.group_last) return;
        o.fact_number = fact_count;
        if (!group_unknown && odd_roots == 0) begin
            o.status = ST_ANSWER;
            o.answer_value = group_xor;
        end else begin
            o.status = ST_UNKNOWN;
        end
        reset_group();
        add_outcome(o);
    endfunction

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // driver
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            send_gap <= 0;
        end else if (i_valid && !o_ready) begin
            // hold the beat
        end else begin
            if (i_valid) begin
                predict({i_command, i_first_index, i_second_index, i_fact_value,
                         i_group_last});
                accepted <= accepted + 1;
            end
            if (send_gap > 0) begin
                i_valid <= 0;
                send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
                item_t it;
                it = pending_items.pop_front();
                i_valid <= 1;
                {i_command, i_first_index, i_second_index, i_fact_value,
                 i_group_last} <= it;
                send_gap <= gap_length();
            end else begin
                i_valid <= 0;
            end
        end
    end

    // monitor and result stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            if (o_valid && i_ready) begin
                outcome_t exp_o;
                results_seen <= results_seen + 1;
                if (expected_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: status %0d count %0d value %0h",
                                 o_status, o_fact_number, o_answer_value);
                end else begin
                    exp_o = expected_outcomes.pop_front();
                    if (exp_o.status == ST_ANSWER) answers_seen++;
                    if (exp_o.status == ST_CONFLICT) conflicts_seen++;
                    if (exp_o.status !== o_status || exp_o.fact_number !== o_fact_number
                        || exp_o.answer_value !== o_answer_value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d/%0h got %0d/%0d/%0h",
                                     exp_o.status, exp_o.fact_number, exp_o.answer_value,
                                     o_status, o_fact_number, o_answer_value);
                    end
                end
            end
            i_ready <= (gap_length() == 0) || ($urandom_range(0, 1) == 1);
        end
    end

    task automatic apb_write(logic [31:0] value);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {REG_NUM_VARS[0], 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        var_count = value[NODE_W-1:0];
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || i_valid || expected_outcomes.size() > 0)
            @(posedge i_clk);
        // unanswered query elements or a clear may still be in flight
        repeat (17000) @(posedge i_clk);
    endtask

    function automatic item_t make_item(logic [1:0] c, int a, int b, int v, bit l);
        item_t it;
        it.command = c;
        it.first_index = a[NODE_W-1:0];
        it.second_index = b[NODE_W-1:0];
        it.fact_value = v[VAL_W-1:0];
        it.group_last = l;
        return it;
    endfunction

    function automatic int pick_index(int nv);
        int p;
        p = $urandom_range(0, 99);
        if (p < 4) return $urandom_range(0, MAX_NODES - 1);
        if (p < 8) return nv;
        return $urandom_range(0, nv);
    endfunction

    task automatic wait_while_full();
        while (pending_items.size() > 8) @(posedge i_clk);
    endtask

    // one phase of random traffic over nv variables
    task automatic random_phase(int nv, int count);
        int known [int];
        int a, b, n, v;
        for (int k = 0; k < count; k++) begin
            int p;
            p = $urandom_range(0, 99);
            if (p < 40) begin
                a = pick_index(nv);
                b = pick_index(nv);
                v = $urandom;
                // mostly consistent facts so the store stays out of conflict
                if ($urandom_range(0, 9) != 0 && known.exists(a) && known.exists(b))
                    v = known[a] ^ known[b];
                if ($urandom_range(0, 3) == 0) begin
                    a = $urandom_range(0, 3); b = $urandom_range(0, 3);
                end
                add_item(make_item(CMD_PAIR, a, b, v, 0));
            end else if (p < 55) begin
                a = pick_index(nv);
                v = known.exists(a) && $urandom_range(0, 9) != 0 ? known[a] : $urandom;
                add_item(make_item(CMD_VALUE, a, $urandom, v, 0));
            end else if (p < 97) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19)
                                                 : $urandom_range(1, 4);
                for (int j = 0; j < n; j++) begin
                    a = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : pick_index(nv);
                    add_item(make_item(CMD_QUERY, a, $urandom, $urandom, j == n - 1));
                end
            end else begin
                add_item(make_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
            end
            // ground truth values keep facts consistent in most cases
            if (!known.exists(a)) known[a] = $urandom & 32'h7fff_ffff;
            if (!known.exists(b)) known[b] = $urandom & 32'h7fff_ffff;
            wait_while_full();
        end
    endtask

    initial begin
        int settings [5];
        settings = '{16383, 7, 1, 300, 1000};
        i_rst_n = 0; i_valid = 0; i_ready = 0;
        i_command = '0; i_first_index = '0; i_second_index = '0;
        i_fact_value = '0; i_group_last = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        mismatches = 0; results_seen = 0; answers_seen = 0; conflicts_seen = 0;
        accepted = 0;
        var_count = MAX_NODES - 1;
        wipe_store();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, every command, special cases
        add_item(make_item(CMD_PAIR, 0, 16383, 32'h7fff_ffff, 0));
        add_item(make_item(CMD_VALUE, 16383, 0, 0, 0));
        add_item(make_item(CMD_PAIR, 1, 2, 5, 0));
        add_item(make_item(CMD_QUERY, 1, 0, 0, 0));
        add_item(make_item(CMD_PAIR, 2, 3, 6, 0));
        add_item(make_item(CMD_QUERY, 3, 0, 0, 1));
        add_item(make_item(CMD_QUERY, 1, 0, 0, 1));
        add_item(make_item(CMD_VALUE, 3, 0, 9, 0));
        add_item(make_item(CMD_QUERY, 2, 0, 0, 1));
        add_item(make_item(CMD_PAIR, 4, 4, 0, 0));
        add_item(make_item(CMD_PAIR, 1, 3, 2, 0));
        add_item(make_item(CMD_QUERY, 1, 0, 0, 1));
        add_item(make_item(CMD_PAIR, 5, 6, 1, 0));
        add_item(make_item(CMD_CLEAR, 0, 0, 0, 0));
        add_item(make_item(CMD_VALUE, 16383, 0, 1, 1));
        add_item(make_item(CMD_CLEAR, 0, 0, 0, 1));
        for (int j = 0; j < 18; j++)
            add_item(make_item(CMD_QUERY, j + 20, 0, 0, j == 17));
        wait_idle();

        // small range with out of range indexes, then the random phases
        apb_write(5);
        add_item(make_item(CMD_PAIR, 6, 7, 1, 0));
        add_item(make_item(CMD_VALUE, 5, 0, 0, 0));
        add_item(make_item(CMD_QUERY, 9, 0, 0, 1));
        wait_idle();
        foreach (settings[s]) begin
            apb_write(settings[s]);
            random_phase(settings[s], 75);
            wait_idle();
        end

        $display("ran %0d beats in, %0d results, %0d answers, %0d conflicts",
                 accepted, results_seen, answers_seen, conflicts_seen);
        $display("register settings covered 1, 5, 7, 300, 1000 and 16383");
        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
